// ===== design/dual_stack_with_merge_dump_macros.svh =====
// Assertion macros shared by the dual stack design.
`ifndef DUAL_STACK_WITH_MERGE_DUMP_MACROS_SVH
`define DUAL_STACK_WITH_MERGE_DUMP_MACROS_SVH

// The condition must never hold outside reset.
`define DSMD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define DSMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/dsmd_pkg.sv =====
// Package with the types, codes and word helpers of the dual stack design.
`default_nettype none

package dsmd_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int WORD_BITS   = 32;
    localparam int FIELD_BITS  = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [2:0] {
        CMD_PUSH_ONE = 3'd0,
        CMD_PUSH_TWO = 3'd1,
        CMD_POP_ONE  = 3'd2,
        CMD_POP_TWO  = 3'd3,
        CMD_MERGE    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } t_state;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [ADDR_W-1:0]     addr;
        logic [WORD_BITS-1:0]  wdata;
    } t_ram_req;

    typedef struct packed {
        logic                  valid;
        logic [FIELD_BITS-1:0] out_word;
        t_status               status;
        logic                  from_second;
        logic                  last;
    } t_result;

    // Keep the low bits of a pushed field; bits above the field are zero.
    function automatic logic [WORD_BITS-1:0] to_store_word(input logic [FIELD_BITS-1:0] f);
        logic [63:0]          ext;
        logic [WORD_BITS-1:0] w;
        ext = 64'(f);
        for (int i = 0; i < WORD_BITS; i++) begin
            w[i] = ext[i];
        end
        return w;
    endfunction

    // Sign-extend a stored word to the field width, or keep its low bits.
    function automatic logic [FIELD_BITS-1:0] to_out_word(input logic [WORD_BITS-1:0] w);
        logic [63:0]           ext;
        logic [FIELD_BITS-1:0] f;
        ext = 64'(w);
        for (int i = 0; i < FIELD_BITS; i++) begin
            f[i] = (i < WORD_BITS) ? ext[i] : ext[WORD_BITS-1];
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== design/dsmd_ram.sv =====
// Single-port synchronous RAM with a registered read port.
`default_nettype none

module dsmd_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic                                        i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/dsmd_ctrl.sv =====
// Command sequencer: stack counts, memory requests and result generation.
`default_nettype none

module dsmd_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [2:0]                     i_cmd,
    input  wire logic [dsmd_pkg::FIELD_BITS-1:0] i_push_word,
    output logic                                o_ready,
    input  wire logic                           i_can_emit,
    output dsmd_pkg::t_result                   o_emit,
    output dsmd_pkg::t_ram_req                  o_req_one,
    output dsmd_pkg::t_ram_req                  o_req_two,
    input  wire logic [dsmd_pkg::WORD_BITS-1:0] i_rd_one,
    input  wire logic [dsmd_pkg::WORD_BITS-1:0] i_rd_two
);

    localparam logic [dsmd_pkg::CNT_W-1:0] CNT_ONE  = dsmd_pkg::CNT_W'(1);
    localparam logic [dsmd_pkg::CNT_W-1:0] CNT_FULL = dsmd_pkg::CNT_W'(dsmd_pkg::STACK_DEPTH);

    dsmd_pkg::t_state                 r_state, n_state;
    logic [dsmd_pkg::CNT_W-1:0]       r_cnt_one, n_cnt_one;
    logic [dsmd_pkg::CNT_W-1:0]       r_cnt_two, n_cnt_two;
    logic                             r_pend, n_pend;
    logic                             r_pend_sel, n_pend_sel;
    logic                             r_pend_last, n_pend_last;
    logic                             r_more, n_more;
    logic                             r_sel, n_sel;
    logic [dsmd_pkg::ADDR_W-1:0]      r_idx, n_idx;

    logic [dsmd_pkg::CNT_W-1:0]       w_dec_one;
    logic [dsmd_pkg::CNT_W-1:0]       w_dec_two;
    logic                             w_adv;

    assign w_dec_one = r_cnt_one - CNT_ONE;
    assign w_dec_two = r_cnt_two - CNT_ONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dsmd_pkg::S_IDLE;
            r_cnt_one <= '0;
            r_cnt_two <= '0;
            r_pend    <= 1'b0;
            r_more    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_one <= n_cnt_one;
            r_cnt_two <= n_cnt_two;
            r_pend    <= n_pend;
            r_more    <= n_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_sel  <= n_pend_sel;
        r_pend_last <= n_pend_last;
        r_sel       <= n_sel;
        r_idx       <= n_idx;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt_one   = r_cnt_one;
        n_cnt_two   = r_cnt_two;
        n_pend      = r_pend;
        n_pend_sel  = r_pend_sel;
        n_pend_last = r_pend_last;
        n_more      = r_more;
        n_sel       = r_sel;
        n_idx       = r_idx;
        o_ready     = 1'b0;
        w_adv       = 1'b0;
        o_emit      = '0;
        o_req_one   = '0;
        o_req_two   = '0;
        o_req_one.wdata = dsmd_pkg::to_store_word(i_push_word);
        o_req_two.wdata = dsmd_pkg::to_store_word(i_push_word);

        case (r_state)
            dsmd_pkg::S_IDLE: begin
                o_ready = i_can_emit;
                if (i_valid && i_can_emit) begin
                    case (i_cmd)
                        dsmd_pkg::CMD_PUSH_ONE: begin
                            o_emit.valid = 1'b1;
                            o_emit.last  = 1'b1;
                            if (r_cnt_one == CNT_FULL) begin
                                o_emit.status = dsmd_pkg::STAT_OVER;
                            end else begin
                                o_req_one.we   = 1'b1;
                                o_req_one.addr = r_cnt_one[dsmd_pkg::ADDR_W-1:0];
                                n_cnt_one      = r_cnt_one + CNT_ONE;
                                o_emit.status  = dsmd_pkg::STAT_OK;
                            end
                        end
                        dsmd_pkg::CMD_PUSH_TWO: begin
                            o_emit.valid = 1'b1;
                            o_emit.last  = 1'b1;
                            if (r_cnt_two == CNT_FULL) begin
                                o_emit.status = dsmd_pkg::STAT_OVER;
                            end else begin
                                o_req_two.we   = 1'b1;
                                o_req_two.addr = r_cnt_two[dsmd_pkg::ADDR_W-1:0];
                                n_cnt_two      = r_cnt_two + CNT_ONE;
                                o_emit.status  = dsmd_pkg::STAT_OK;
                            end
                        end
                        dsmd_pkg::CMD_POP_ONE: begin
                            if (r_cnt_one == '0) begin
                                o_emit.valid  = 1'b1;
                                o_emit.last   = 1'b1;
                                o_emit.status = dsmd_pkg::STAT_UNDER;
                            end else begin
                                o_req_one.re   = 1'b1;
                                o_req_one.addr = w_dec_one[dsmd_pkg::ADDR_W-1:0];
                                n_cnt_one      = w_dec_one;
                                n_pend         = 1'b1;
                                n_pend_sel     = 1'b0;
                                n_pend_last    = 1'b1;
                                n_more         = 1'b0;
                                n_state        = dsmd_pkg::S_BUSY;
                            end
                        end
                        dsmd_pkg::CMD_POP_TWO: begin
                            if (r_cnt_two == '0) begin
                                o_emit.valid       = 1'b1;
                                o_emit.last        = 1'b1;
                                o_emit.from_second = 1'b1;
                                o_emit.status      = dsmd_pkg::STAT_UNDER;
                            end else begin
                                o_req_two.re   = 1'b1;
                                o_req_two.addr = w_dec_two[dsmd_pkg::ADDR_W-1:0];
                                n_cnt_two      = w_dec_two;
                                n_pend         = 1'b1;
                                n_pend_sel     = 1'b1;
                                n_pend_last    = 1'b1;
                                n_more         = 1'b0;
                                n_state        = dsmd_pkg::S_BUSY;
                            end
                        end
                        dsmd_pkg::CMD_MERGE: begin
                            if (r_cnt_one == '0 && r_cnt_two == '0) begin
                                o_emit.valid  = 1'b1;
                                o_emit.last   = 1'b1;
                                o_emit.status = dsmd_pkg::STAT_EMPTY;
                            end else begin
                                if (r_cnt_one != '0) begin
                                    n_sel = 1'b0;
                                    n_idx = w_dec_one[dsmd_pkg::ADDR_W-1:0];
                                end else begin
                                    n_sel = 1'b1;
                                    n_idx = w_dec_two[dsmd_pkg::ADDR_W-1:0];
                                end
                                n_pend  = 1'b0;
                                n_more  = 1'b1;
                                n_state = dsmd_pkg::S_BUSY;
                            end
                        end
                        default: begin
                            // Undefined commands are taken and dropped.
                        end
                    endcase
                end
            end
            dsmd_pkg::S_BUSY: begin
                // The held read data moves on once the result slot frees up.
                w_adv = !r_pend || i_can_emit;
                if (r_pend && i_can_emit) begin
                    o_emit.valid       = 1'b1;
                    o_emit.out_word    = dsmd_pkg::to_out_word(r_pend_sel ? i_rd_two
                                                                          : i_rd_one);
                    o_emit.status      = dsmd_pkg::STAT_OK;
                    o_emit.from_second = r_pend_sel;
                    o_emit.last        = r_pend_last;
                end
                if (w_adv) begin
                    if (r_more) begin
                        if (r_sel) begin
                            o_req_two.re   = 1'b1;
                            o_req_two.addr = r_idx;
                        end else begin
                            o_req_one.re   = 1'b1;
                            o_req_one.addr = r_idx;
                        end
                        n_pend     = 1'b1;
                        n_pend_sel = r_sel;
                        if (r_idx == '0) begin
                            if (!r_sel && r_cnt_two != '0) begin
                                n_sel       = 1'b1;
                                n_idx       = w_dec_two[dsmd_pkg::ADDR_W-1:0];
                                n_pend_last = 1'b0;
                            end else begin
                                n_more      = 1'b0;
                                n_pend_last = 1'b1;
                            end
                        end else begin
                            n_idx       = r_idx - dsmd_pkg::ADDR_W'(1);
                            n_pend_last = 1'b0;
                        end
                    end else begin
                        n_pend  = 1'b0;
                        n_state = dsmd_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = dsmd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/dual_stack_with_merge_dump.sv =====
// Top level of the dual stack: two stack memories, the sequencer and the result register.
// Push, error and empty-merge results pass only through the result register; a pop result
// first passes the read register of its stack memory, and a merge issues its first read only
// after the input transfer. Pushes and errors are taken back to back while results drain;
// a pop or merge keeps the sequencer busy, paced by registered reads and one read port per stack.
// Reset clears both counts, the sequencer and the result valid; stack memories are not cleared.
`default_nettype none
`include "dual_stack_with_merge_dump_macros.svh"

module dual_stack_with_merge_dump (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_cmd,
    input  wire logic signed [31:0] i_push_word,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_out_word,
    output logic [1:0]              o_status,
    output logic                    o_from_second,
    output logic                    o_last
);

    // Requests from the sequencer to each stack memory, and the data read back.
    dsmd_pkg::t_ram_req              w_req_one;
    dsmd_pkg::t_ram_req              w_req_two;
    logic [dsmd_pkg::WORD_BITS-1:0]  w_rd_one;
    logic [dsmd_pkg::WORD_BITS-1:0]  w_rd_two;

    // A result produced by the sequencer this cycle.
    dsmd_pkg::t_result               w_emit;
    logic                            w_can_emit;

    // Result register that parts the sequencer from the output channel.
    logic                            r_o_valid;
    logic [31:0]                     r_o_word;
    dsmd_pkg::t_status               r_o_status;
    logic                            r_o_second;
    logic                            r_o_last;

    // The sequencer may hand over a result when the register is empty or drains now.
    assign w_can_emit = !r_o_valid || i_ready;

    dsmd_ram #(
        .DEPTH (dsmd_pkg::STACK_DEPTH),
        .WIDTH (dsmd_pkg::WORD_BITS)
    ) u_ram_one (
        .i_clk   (i_clk),
        .i_we    (w_req_one.we),
        .i_re    (w_req_one.re),
        .i_addr  (w_req_one.addr),
        .i_wdata (w_req_one.wdata),
        .o_rdata (w_rd_one)
    );

    dsmd_ram #(
        .DEPTH (dsmd_pkg::STACK_DEPTH),
        .WIDTH (dsmd_pkg::WORD_BITS)
    ) u_ram_two (
        .i_clk   (i_clk),
        .i_we    (w_req_two.we),
        .i_re    (w_req_two.re),
        .i_addr  (w_req_two.addr),
        .i_wdata (w_req_two.wdata),
        .o_rdata (w_rd_two)
    );

    dsmd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cmd       (i_cmd),
        .i_push_word (i_push_word),
        .o_ready     (o_ready),
        .i_can_emit  (w_can_emit),
        .o_emit      (w_emit),
        .o_req_one   (w_req_one),
        .o_req_two   (w_req_two),
        .i_rd_one    (w_rd_one),
        .i_rd_two    (w_rd_two)
    );

    // The valid bit is control state; the payload only loads with a new result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit.valid) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_o_word   <= w_emit.out_word;
            r_o_status <= w_emit.status;
            r_o_second <= w_emit.from_second;
            r_o_last   <= w_emit.last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_word    = r_o_word;
    assign o_status      = r_o_status;
    assign o_from_second = r_o_second;
    assign o_last        = r_o_last;

    // A new result must never overwrite one that is still waiting for its transfer.
    `DSMD_ASSERT_IMPLY(a_no_result_overwrite, i_clk, i_rst_n, w_emit.valid,
        (!r_o_valid || i_ready), "result register overwritten while stalled")

    // Only one stack is read per cycle, since a single result register follows.
    `DSMD_ASSERT_NEVER(a_single_read, i_clk, i_rst_n, (w_req_one.re && w_req_two.re),
        "both stack memories read in the same cycle")

    // Stack memories are written only by a push that is transferred in this cycle.
    `DSMD_ASSERT_IMPLY(a_write_on_transfer, i_clk, i_rst_n, (w_req_one.we || w_req_two.we),
        (i_valid && o_ready), "stack write without an input transfer")

endmodule

`default_nettype wire
